@@ design/twt_pkg.sv @@
// Shared types, constants and command/status bundles for the timed wakeup table.
// Used by twt_ctrl, twt_dp, timed_wakeup_table_top and tb_top; depends on nothing else.
package twt_pkg;

  // Table geometry. The slot count may range from 2 to 32.
  localparam int TASK_SLOTS = 32;
  localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  // Fixed field widths.
  localparam int ACTION_W = 2;
  localparam int TASK_W   = 5;
  localparam int TIME_W   = 32;
  localparam int KIND_W   = 2;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_W  = 40;
  localparam int OUT_W = 40;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [TASK_W-1:0] task_t;
  typedef logic [TIME_W-1:0] time_t;

  localparam slot_t LAST_SLOT = slot_t'(TASK_SLOTS - 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK      = 2'd0,
    ACT_QUERY     = 2'd1,
    ACT_DELAY_REL = 2'd2,
    ACT_DELAY_ABS = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK    = 2'd0,
    KIND_TIME   = 2'd1,
    KIND_WAKE   = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  tick_start;   // bump the count, hold the acknowledge, rewind the scan
    logic  store_delay;  // write a deadline and set the pending mark
    logic  push_direct;  // load a single-beat result into the output register
    kind_t direct_kind;
    logic  scan_step;    // retire the current slot and move on
    logic  push_held;    // move the held result into the output register
    logic  held_last;
  } twt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic push_ok;  // output register is free or drains this cycle
    logic hit;      // current slot is pending and due
    logic at_last;  // scan index sits on the last slot
  } twt_status_t;

  // True when a task id names a slot that exists in the table.
  function automatic logic slot_in_range(input task_t t);
    return int'(t) < TASK_SLOTS;
  endfunction

endpackage

@@ design/twt_ctrl.sv @@
// Controller state machine for the timed wakeup table.
// Depends on twt_pkg; drives twt_dp through the command bundle.
module twt_ctrl
  import twt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  action_t     action,
  input  logic        amount_neg,
  input  twt_status_t status,
  output twt_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_PREP  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;
  logic   step;

  // A new item is taken only from idle, and only when its result has a place to go.
  assign s_tready = (state == S_IDLE) && status.push_ok;
  assign take     = s_tvalid && s_tready;

  // A slot that is due must wait until the output register can take the held beat.
  assign step = (state == S_SCAN) && (!status.hit || status.push_ok);

  // Command decode and next state.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (take) begin
          case (action)
            ACT_TICK: begin
              cmd.tick_start = 1'b1;
              state_next     = S_PREP;
            end
            ACT_QUERY: begin
              cmd.push_direct = 1'b1;
              cmd.direct_kind = KIND_TIME;
            end
            default: begin
              if (amount_neg) begin
                cmd.push_direct = 1'b1;
                cmd.direct_kind = KIND_REJECT;
              end else begin
                cmd.store_delay = 1'b1;
              end
            end
          endcase
        end
      end
      S_PREP: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = step;
        cmd.push_held = step && status.hit;
        cmd.held_last = 1'b0;
        if (step && status.at_last) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (status.push_ok) begin
          cmd.push_held = 1'b1;
          cmd.held_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Leaving the last slot always lands in the flush of the held beat.
  a_scan_ends_in_flush: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && step && status.at_last) |=> (state == S_FLUSH))
    else $error("scan of the last slot did not move to flush");

endmodule

@@ design/twt_dp.sv @@
// Datapath of the timed wakeup table: tick count, deadline memory, pending marks,
// held result and output register. Depends on twt_pkg; steered by twt_ctrl.
module twt_dp
  import twt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  action_t            action,
  input  task_t              task_id,
  input  time_t              amount,
  input  twt_cmd_t           cmd,
  output twt_status_t        status,
  output logic               m_tvalid,
  input  logic               m_tready,
  output kind_t              out_kind,
  output task_t              out_task,
  output time_t              out_time,
  output logic               out_last
);

  time_t                 count;
  time_t                 deadline_mem [TASK_SLOTS];
  time_t                 rd_data;
  slot_t                 rd_addr;
  logic [TASK_SLOTS-1:0] pending;
  slot_t                 idx;
  kind_t                 held_kind;
  task_t                 held_task;
  logic                  push;
  time_t                 new_deadline;

  // Status toward the controller.
  assign status.push_ok = !m_tvalid || m_tready;
  assign status.hit     = pending[idx] && (rd_data <= count);
  assign status.at_last = (idx == LAST_SLOT);

  assign push = cmd.push_direct || cmd.push_held;

  // The read address runs one slot ahead when the scan advances.
  assign rd_addr = (cmd.scan_step && !status.at_last) ? idx + slot_t'(1) : idx;

  assign new_deadline = (action == ACT_DELAY_REL) ? amount + count : amount;

  // Deadline memory: one write port for delays, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (cmd.store_delay && slot_in_range(task_id)) begin
      deadline_mem[slot_t'(task_id)] <= new_deadline;
    end
    rd_data <= deadline_mem[rd_addr];
  end

  // Tick count, pending marks and scan index.
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      pending <= '0;
      idx     <= '0;
    end else begin
      if (cmd.tick_start) begin
        count <= count + time_t'(1);
        idx   <= '0;
      end
      if (cmd.store_delay && slot_in_range(task_id)) begin
        pending[slot_t'(task_id)] <= 1'b1;
      end
      if (cmd.scan_step) begin
        if (status.hit) begin
          pending[idx] <= 1'b0;
        end
        if (!status.at_last) begin
          idx <= idx + slot_t'(1);
        end
      end
    end
  end

  // Held result: the acknowledge, then each wake, waits here until the next one shows up.
  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      held_kind <= KIND_ACK;
      held_task <= task_id;
    end else if (cmd.scan_step && status.hit) begin
      held_kind <= KIND_WAKE;
      held_task <= task_t'(idx);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output register payload; every beat carries the count as it stands.
  always_ff @(posedge clk) begin
    if (push) begin
      out_time <= count;
      if (cmd.push_direct) begin
        out_kind <= cmd.direct_kind;
        out_task <= task_id;
        out_last <= 1'b1;
      end else begin
        out_kind <= held_kind;
        out_task <= held_task;
        out_last <= cmd.held_last;
      end
    end
  end

  // A beat is loaded only when the output register has room for it.
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!m_tvalid || m_tready))
    else $error("result loaded over an untaken beat");

  // A slot that wakes loses its pending mark.
  a_wake_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step && status.hit) |=> !pending[$past(idx)])
    else $error("woken slot still pending");

  // A tick advances the count by exactly one.
  a_tick_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_start |=> (count == $past(count) + time_t'(1)))
    else $error("tick did not advance the count by one");

endmodule

@@ design/timed_wakeup_table_top.sv @@
// Top level of the timed wakeup table: stream ports, controller and datapath.
// A query or a rejected delay is in the output register in the cycle after its beat is taken.
// A tick runs a prep state, then a scan that reads one slot a cycle from the deadline memory
// unless a due slot waits on the output register, then a flush. A delay is stored when taken.
// Reset clears the tick count, all pending marks, the state machine and the output valid.
// Depends on twt_pkg, twt_ctrl and twt_dp.
module timed_wakeup_table_top
  import twt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // action[1:0], task_id[6:2], amount[38:7], zero[39]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // kind[1:0], target_task[6:2], time_value[38:7], zero[39]
  output logic             m_tlast
);

  twt_cmd_t    cmd;
  twt_status_t status;
  action_t     action;
  task_t       task_id;
  time_t       amount;
  kind_t       out_kind;
  task_t       out_task;
  time_t       out_time;

  // Unpack the input beat.
  assign action  = action_t'(s_tdata[ACTION_W-1:0]);
  assign task_id = s_tdata[ACTION_W +: TASK_W];
  assign amount  = s_tdata[ACTION_W+TASK_W +: TIME_W];

  // Pack the output beat.
  assign m_tdata = {1'b0, out_time, out_task, out_kind};

  twt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .action     (action),
    .amount_neg (amount[TIME_W-1]),
    .status     (status),
    .cmd        (cmd)
  );

  twt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .action   (action),
    .task_id  (task_id),
    .amount   (amount),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_kind (out_kind),
    .out_task (out_task),
    .out_time (out_time),
    .out_last (m_tlast)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for timed_wakeup_table_top: a scoreboard predicts every result beat.
// It depends on twt_pkg and on the RTL of the timed wakeup table; it reads no files.
module tb_top
  import twt_pkg::*;
();

  // Cycles with no beat on either side before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  // Quiet cycles after the last result, enough for a full table scan.
  localparam int SETTLE_CYCLES = TASK_SLOTS + 8;

  typedef struct {
    kind_t kind;
    task_t target;
    time_t tval;
    logic  last;
  } timer_reply_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             m_tlast;

  // Mirror of the block's timer state, advanced at every accepted input beat.
  time_t        sched_count;
  time_t        sched_deadline [TASK_SLOTS];
  bit           sched_armed [TASK_SLOTS];
  timer_reply_t replies_due [$];

  int mismatch_count = 0;
  int hold_len = 0;
  bit steady_flow = 1'b0;

  timed_wakeup_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
    $display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want, seen);
    mismatch_count++;
  endtask

  // Apply one input beat to the timer mirror and queue the result beats it causes.
  task automatic advance_timer_table(input action_t act, input task_t tid, input time_t amt);
    int woken [$];
    case (act)
      ACT_TICK: begin
        sched_count = sched_count + 1;
        for (int i = 0; i < TASK_SLOTS; i++) begin
          if (sched_armed[i] && sched_deadline[i] <= sched_count) begin
            sched_armed[i] = 1'b0;
            sched_deadline[i] = '0;
            woken.push_back(i);
          end
        end
        replies_due.push_back('{KIND_ACK, tid, sched_count, woken.size() == 0});
        foreach (woken[k]) begin
          replies_due.push_back('{KIND_WAKE, task_t'(woken[k]), sched_count,
                                  k == woken.size() - 1});
        end
      end
      ACT_QUERY: replies_due.push_back('{KIND_TIME, tid, sched_count, 1'b1});
      default: begin
        // A negative amount is refused and the slot keeps its old entry.
        if (amt[TIME_W-1]) begin
          replies_due.push_back('{KIND_REJECT, tid, sched_count, 1'b1});
        end else if (int'(tid) < TASK_SLOTS) begin
          sched_deadline[tid] = (act == ACT_DELAY_REL) ? amt + sched_count : amt;
          sched_armed[tid] = 1'b1;
        end
      end
    endcase
  endtask

  // Offer one beat, wait for the handshake, then leave a random gap unless the flow is steady.
  task automatic send_beat(input action_t act, input task_t tid, input time_t amt);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, amt, tid, act};
    do @(posedge clk); while (!s_tready);
    advance_timer_table(act, tid, amt);
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result-side ready: random stalls, steady stretches, and a requested long hold.
  initial begin
    int ready_stall;
    ready_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (steady_flow) begin
        m_tready <= 1'b1;
      end else if (ready_stall > 0) begin
        m_tready <= 1'b0;
        ready_stall--;
      end else if ($urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        ready_stall = pick_gap();
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare every accepted result beat with the oldest prediction.
  always @(posedge clk) begin
    timer_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (replies_due.size() == 0) begin
        flag_mismatch("unexpected result beat", '0, m_tdata[38:7]);
      end else begin
        want = replies_due.pop_front();
        if (m_tdata[1:0] != want.kind)
          flag_mismatch("kind", 32'(want.kind), 32'(m_tdata[1:0]));
        if (m_tdata[6:2] != want.target)
          flag_mismatch("target_task", 32'(want.target), 32'(m_tdata[6:2]));
        if (m_tdata[38:7] != want.tval) flag_mismatch("time_value", want.tval, m_tdata[38:7]);
        if (m_tlast != want.last) flag_mismatch("last", 32'(want.last), 32'(m_tlast));
        if (m_tdata[39] != 1'b0) flag_mismatch("pad bit", 32'd0, 32'(m_tdata[39]));
      end
    end
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk) begin
    int idle_cycles;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Field extremes, each action, and the corner cases of the wake logic.
  task automatic test_directed();
    send_beat(ACT_TICK, 5'd0, 32'h0);                 // tick with nothing pending
    send_beat(ACT_QUERY, 5'd31, 32'hFFFF_FFFF);
    send_beat(ACT_DELAY_REL, 5'd3, 32'h8000_0000);    // most negative amount refused
    send_beat(ACT_DELAY_ABS, 5'd4, 32'hFFFF_FFFF);    // minus one refused
    send_beat(ACT_DELAY_REL, 5'd0, 32'h0);            // deadline already reached
    send_beat(ACT_DELAY_ABS, 5'd31, 32'h0);           // deadline already passed
    send_beat(ACT_TICK, 5'd17, 32'h0);                // wakes slot 0 then slot 31
    send_beat(ACT_DELAY_REL, 5'd7, 32'd10);
    send_beat(ACT_DELAY_REL, 5'd7, 32'd1);            // overwrite a pending deadline
    send_beat(ACT_DELAY_REL, 5'd7, 32'hC000_0000);    // refusal leaves slot 7 armed
    send_beat(ACT_DELAY_ABS, 5'd5, 32'h7FFF_FFFF);
    send_beat(ACT_DELAY_ABS, 5'd10, 32'h2AAA_AAAA);
    send_beat(ACT_DELAY_ABS, 5'd21, 32'h5555_5555);
    send_beat(ACT_TICK, 5'd21, 32'h0);
    send_beat(ACT_DELAY_REL, 5'd12, 32'h7FFF_FFFF);   // largest relative delay
    send_beat(ACT_DELAY_ABS, 5'd5, 32'd4);
    send_beat(ACT_DELAY_REL, 5'd9, 32'd1);
    send_beat(ACT_TICK, 5'd10, 32'h0);                // wakes slots 5 and 9
    send_beat(ACT_TICK, 5'd31, 32'h0);
    send_beat(ACT_QUERY, 5'd10, 32'h0);
    send_beat(ACT_DELAY_ABS, 5'd10, 32'h0);
    send_beat(ACT_TICK, 5'd2, 32'h0);
    drain_results();
  endtask

  // Arm every slot, highest first, so one tick must wake the whole table in slot order.
  task automatic test_full_table();
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      send_beat(ACT_DELAY_REL, task_t'(i), time_t'($urandom_range(0, 1)));
    end
    send_beat(ACT_TICK, task_t'($urandom_range(0, 31)), $urandom());
    drain_results();
  endtask

  // The receiver holds off for a long time while beats keep coming back to back.
  task automatic test_backpressure();
    hold_len = 300;
    steady_flow = 1'b1;
    for (int i = 0; i < 14; i++) begin
      case (i % 4)
        0: send_beat(ACT_DELAY_REL, task_t'($urandom_range(0, 31)), time_t'(i % 2));
        1: send_beat(ACT_QUERY, task_t'($urandom_range(0, 31)), $urandom());
        default: send_beat(ACT_TICK, task_t'($urandom_range(0, 31)), $urandom());
      endcase
    end
    steady_flow = 1'b0;
    drain_results();
  endtask

  // Mostly short delays that fall due soon, mixed with ticks, queries and wild amounts.
  task automatic test_random_traffic(input int beats);
    int pick;
    task_t tid;
    time_t amt;
    for (int n = 0; n < beats; n++) begin
      if (n % 25 == 0) steady_flow = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      tid = task_t'($urandom_range(0, 31));
      if (pick < 30) begin
        send_beat(ACT_TICK, tid, $urandom());
      end else if (pick < 40) begin
        send_beat(ACT_QUERY, tid, $urandom());
      end else if (pick < 65) begin
        send_beat(ACT_DELAY_REL, tid, time_t'($urandom_range(0, 6)));
      end else if (pick < 78) begin
        amt = sched_count + time_t'($urandom_range(0, 8)) - 32'd2;
        send_beat(ACT_DELAY_ABS, tid, amt);
      end else begin
        send_beat($urandom_range(0, 1) ? ACT_DELAY_ABS : ACT_DELAY_REL, tid, $urandom());
      end
    end
    steady_flow = 1'b0;
    drain_results();
  endtask

  initial begin
    sched_count = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      sched_deadline[i] = '0;
      sched_armed[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_table();
    test_backpressure();
    test_random_traffic(140);

    if (replies_due.size() != 0) begin
      flag_mismatch("results never delivered", 32'(replies_due.size()), 32'd0);
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
